### src/ccdr_pkg.sv
// Package for the CC/CV DAC regulator: constants, codes, state encoding,
// controller/datapath structs and the dead-band helper.
// No dependencies; every other file of the block imports it.
package ccdr_pkg;

    localparam int AVG_DEPTH      = 8;
    localparam int ADC_FULL_SCALE = 65535;
    localparam int GAIN_LOWEST    = 0;
    localparam int GAIN_HIGHEST   = 7;
    localparam int DAC_FLOOR      = 640;
    localparam int DAC_CEILING    = 4095;

    localparam int SAMPLE_W = 20;
    localparam int RAW_W    = 16;
    localparam int DAC_W    = 12;
    localparam int GAIN_W   = 3;
    localparam int HOLD_W   = 8;
    localparam int TIME_W   = 32;
    localparam int MV_W     = 16;
    localparam int SEC_W    = 16;
    localparam int LVL_W    = 19;
    localparam int RUN_W    = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam int AVG_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_W + FILL_W;
    localparam int DIFF_W    = 24;
    localparam int DCALC_W   = 16;

    // shared divider: 32-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DIV_W = 32;
    localparam int DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [RAW_W-1:0] RAW_OVERLOAD = RAW_W'((ADC_FULL_SCALE * 99) / 100);
    localparam logic [RAW_W-1:0] RAW_GAIN_UP  = RAW_W'(ADC_FULL_SCALE / 3);
    localparam logic [RAW_W-1:0] RAW_GAIN_DN  = RAW_W'((3 * ADC_FULL_SCALE) / 4);
    localparam logic [GAIN_W-1:0] GAIN_STEP_LO = GAIN_W'(GAIN_LOWEST);
    localparam logic [GAIN_W-1:0] GAIN_STEP_HI = GAIN_W'(GAIN_HIGHEST);
    localparam logic [DAC_W-1:0]  DAC_FLOOR_U = DAC_W'(DAC_FLOOR);
    localparam logic signed [DCALC_W-1:0] DAC_FLOOR_S = DCALC_W'(DAC_FLOOR);
    localparam logic signed [DCALC_W-1:0] DAC_CEIL_S  = DCALC_W'(DAC_CEILING);

    localparam logic [HOLD_W-1:0] HOLD_SHORT = 8'd3;
    localparam logic [HOLD_W-1:0] HOLD_DISC  = 8'd1;
    localparam logic [RUN_W-1:0]  VDEC_LIMIT = 5'd25;

    localparam logic signed [SAMPLE_W-1:0] I_FLOW_MIN  = 20'sd100;
    localparam logic signed [SAMPLE_W-1:0] V_OPEN_MIN  = 20'sd25000;
    localparam logic signed [DIFF_W-1:0]   TRIP_VCUR   = -24'sd3500;
    localparam logic signed [DIFF_W-1:0]   TRIP_VAVG   = -24'sd1000;
    localparam logic signed [DIFF_W-1:0]   TRIP_ICUR   = -24'sd1000;
    localparam logic signed [DIFF_W-1:0]   TRIP_IAVG   = -24'sd500;
    localparam logic signed [DIFF_W-1:0]   RISE_BIG    = 24'sd500;
    localparam logic signed [DIFF_W-1:0]   RISE_SMALL  = 24'sd50;

    // alarm bit positions
    localparam int AL_DISC   = 0;
    localparam int AL_SHORT  = 1;
    localparam int AL_PERIOD = 2;

    typedef enum logic [1:0] {
        CMD_VOLT = 2'd0,
        CMD_CURR = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ADJ_NONE = 2'd0,
        ADJ_VDEC = 2'd1,
        ADJ_IDEC = 2'd2,
        ADJ_IINC = 2'd3
    } t_adj;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE      = 3'd0,
        REG_CALIB       = 3'd1,
        REG_SET_V       = 3'd2,
        REG_SET_I       = 3'd3,
        REG_SHORT_LVL   = 3'd4,
        REG_CYC_PERIOD  = 3'd5,
        REG_CYC_DUTY    = 3'd6,
        REG_CYC_LIMIT   = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_ADJUST,
        ST_TICK_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_start;
        logic div_mod;
        logic avg_write;
        logic mod_write;
        logic adjust;
        logic tick_end;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic      in_valid;
        t_cmd_code code;
        logic      err;
        logic      div_done;
        logic      out_free;
    } t_dp_stat;

    function automatic logic signed [DIFF_W-1:0] dead_band(input logic signed [DIFF_W-1:0] d);
        dead_band = (d > -24'sd5 && d < 24'sd5) ? '0 : d;
    endfunction

endpackage

### src/ccdr_ifs.sv
// Handshake channels of the CC/CV DAC regulator: sample in, result out,
// register write. Depends on ccdr_pkg.
interface ccdr_in_if import ccdr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 command;
    logic                       sample_error;
    logic [RAW_W-1:0]           raw_code;
    logic signed [SAMPLE_W-1:0] sample_value;
    modport source (output valid, command, sample_error, raw_code, sample_value, input ready);
    modport sink   (input valid, command, sample_error, raw_code, sample_value, output ready);
endinterface

interface ccdr_out_if import ccdr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [DAC_W-1:0]           dac_value;
    logic                       dac_written;
    logic [GAIN_W-1:0]          adc_gain;
    logic                       flag_disconnect;
    logic                       flag_short;
    logic                       flag_period_off;
    logic [HOLD_W-1:0]          holdoff_seconds;
    logic [1:0]                 last_adjust;
    logic signed [SAMPLE_W-1:0] voltage_average;
    logic signed [SAMPLE_W-1:0] current_average;
    modport source (output valid, dac_value, dac_written, adc_gain, flag_disconnect,
                    flag_short, flag_period_off, holdoff_seconds, last_adjust,
                    voltage_average, current_average, input ready);
    modport sink   (input valid, dac_value, dac_written, adc_gain, flag_disconnect,
                    flag_short, flag_period_off, holdoff_seconds, last_adjust,
                    voltage_average, current_average, output ready);
endinterface

interface ccdr_cfg_if import ccdr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/ccdr_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ccdr_pkg.
module ccdr_div import ccdr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_q, n_q;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [DEN_W:0]       shifted;
    logic                 fits;

    always_comb begin
        shifted = {r_rem, r_q[DIV_W-1]};
        fits    = shifted >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_W - 1);
            n_q    = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? DEN_W'(shifted - {1'b0, r_den}) : DEN_W'(shifted);
            n_q   = {r_q[DIV_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

### src/ccdr_ctrl.sv
// Sequencer of the CC/CV DAC regulator: walks one request through update,
// averaging, phase and rule steps. Depends on ccdr_pkg.
module ccdr_ctrl import ccdr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_ready
);
    t_state r_state, n_state;
    logic   sample_ok;

    assign sample_ok = (i_stat.code == CMD_VOLT || i_stat.code == CMD_CURR) && !i_stat.err;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_stat.in_valid) n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (sample_ok)                     n_state = ST_AVG_GO;
                else if (i_stat.code == CMD_TICK)  n_state = ST_MOD_GO;
                else                               n_state = ST_DONE;
            end
            ST_AVG_GO:   n_state = ST_AVG_WAIT;
            ST_AVG_WAIT: if (i_stat.div_done) begin
                n_state = (i_stat.code == CMD_CURR) ? ST_MOD_GO : ST_DONE;
            end
            ST_MOD_GO:   n_state = ST_MOD_WAIT;
            ST_MOD_WAIT: if (i_stat.div_done) begin
                n_state = (i_stat.code == CMD_CURR) ? ST_ADJUST : ST_TICK_END;
            end
            ST_ADJUST:   n_state = ST_DONE;
            ST_TICK_END: n_state = ST_DONE;
            ST_DONE:     if (i_stat.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.capture   = (r_state == ST_IDLE) && i_stat.in_valid;
        o_cmd.update    = (r_state == ST_UPDATE);
        o_cmd.div_start = (r_state == ST_AVG_GO) || (r_state == ST_MOD_GO);
        o_cmd.div_mod   = (r_state == ST_MOD_GO);
        o_cmd.avg_write = (r_state == ST_AVG_WAIT) && i_stat.div_done;
        o_cmd.mod_write = (r_state == ST_MOD_WAIT) && i_stat.div_done;
        o_cmd.adjust    = (r_state == ST_ADJUST);
        o_cmd.tick_end  = (r_state == ST_TICK_END);
        o_cmd.load_out  = (r_state == ST_DONE) && i_stat.out_free;
        o_in_ready      = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == ST_AVG_WAIT || r_state == ST_MOD_WAIT))
        else $error("divider finished outside a wait step");
    a_accept_goes_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_stat.in_valid) |=> (r_state == ST_UPDATE))
        else $error("accepted request did not start the update step");
endmodule

### src/ccdr_dp.sv
// Datapath of the CC/CV DAC regulator: registers, averaging rings, uptime,
// DAC rule evaluation and result register. Depends on ccdr_pkg, ccdr_div.
module ccdr_dp import ccdr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_in_valid,
    input  logic [1:0]                 i_command,
    input  logic                       i_sample_error,
    input  logic [RAW_W-1:0]           i_raw_code,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [DAC_W-1:0]           o_dac_value,
    output logic                       o_dac_written,
    output logic [GAIN_W-1:0]          o_adc_gain,
    output logic                       o_flag_disconnect,
    output logic                       o_flag_short,
    output logic                       o_flag_period_off,
    output logic [HOLD_W-1:0]          o_holdoff_seconds,
    output logic [1:0]                 o_last_adjust,
    output logic signed [SAMPLE_W-1:0] o_voltage_average,
    output logic signed [SAMPLE_W-1:0] o_current_average
);
    // configuration
    logic               r_enable, r_calib;
    logic [MV_W-1:0]    r_set_v, r_set_i, r_limit;
    logic [LVL_W-1:0]   r_short_lvl;
    logic [SEC_W-1:0]   r_period, r_duty;

    // captured request
    t_cmd_code                  r_code;
    logic                       r_err;
    logic [RAW_W-1:0]           r_raw;
    logic signed [SAMPLE_W-1:0] r_val;

    // averaging
    logic signed [SAMPLE_W-1:0] r_vring [AVG_DEPTH];
    logic signed [SAMPLE_W-1:0] r_iring [AVG_DEPTH];
    logic signed [SUM_W-1:0]    r_vsum, n_vsum, r_isum, n_isum;
    logic [FILL_W-1:0]          r_vfill, n_vfill, r_ifill, n_ifill;
    logic [AVG_IDX_W-1:0]       r_vslot, n_vslot, r_islot, n_islot;
    logic signed [SAMPLE_W-1:0] r_vlatest, n_vlatest;
    logic signed [SAMPLE_W-1:0] r_vavg, n_vavg, r_iavg, n_iavg;
    logic                       r_neg;
    logic [DEN_W-1:0]           r_phase;

    // regulation state
    logic [DAC_W-1:0]  r_dac, n_dac;
    logic [GAIN_W-1:0] r_gain, n_gain;
    t_adj              r_adj, n_adj;
    logic [RUN_W-1:0]  r_vrun, n_vrun;
    logic [TIME_W-1:0] r_uptime, n_uptime;
    logic [TIME_W-1:0] r_short_until, n_short_until, r_disc_until, n_disc_until;
    logic [HOLD_W-1:0] r_holdoff, n_holdoff;
    logic [2:0]        r_alarm, n_alarm;
    logic              r_written, n_written;
    logic              r_o_valid;

    // divider hookup
    logic                    div_done;
    logic [DIV_W-1:0]        div_quot, div_dividend, q_signed;
    logic [DEN_W-1:0]        div_rem, div_divisor;
    logic signed [SUM_W-1:0] sum_sel;
    logic [DIV_W-1:0]        sum_ext;
    logic                    is_curr;

    // rule evaluation
    logic [19:0]               setv10, seti10, lim10;
    logic signed [DIFF_W-1:0]  dv_avg, dv_cur, di_avg, di_cur;
    logic signed [DCALC_W-1:0] dac0, dac_w;
    logic [2:0]                alarm_w;
    logic                      off, vcap, short_hit;
    logic [TIME_W-1:0]         now_t, dd, sd;
    logic [HOLD_W-1:0]         h_w;

    assign is_curr = (r_code == CMD_CURR);
    assign sum_sel = is_curr ? r_isum : r_vsum;
    assign sum_ext = DIV_W'(sum_sel);
    assign div_dividend = i_cmd.div_mod ? r_uptime
                        : (sum_sel < 0 ? (~sum_ext + 1'b1) : sum_ext);
    assign div_divisor  = i_cmd.div_mod ? r_period
                        : DEN_W'(is_curr ? r_ifill : r_vfill);
    assign q_signed     = r_neg ? (~div_quot + 1'b1) : div_quot;

    ccdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.code     = r_code;
    assign o_stat.err      = r_err;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    // differences against the setpoints
    always_comb begin
        setv10 = 20'(r_set_v) * 20'd10;
        seti10 = 20'(r_set_i) * 20'd10;
        lim10  = 20'(r_limit) * 20'd10;
        dv_avg = dead_band($signed({4'b0, setv10}) - DIFF_W'(r_vavg));
        dv_cur = dead_band($signed({4'b0, setv10}) - DIFF_W'(r_vlatest));
        di_avg = dead_band($signed({4'b0, seti10}) - DIFF_W'(r_iavg));
        di_cur = dead_band($signed({4'b0, seti10}) - DIFF_W'(r_val));
        dac0   = $signed({{(DCALC_W-DAC_W){1'b0}}, r_dac});
        short_hit = ($signed({2'b00, r_short_lvl}) >= 21'(r_vavg))
                 && (r_iavg >= I_FLOW_MIN) && (r_dac > DAC_FLOOR_U);
    end

    always_comb begin
        n_vsum = r_vsum;   n_isum = r_isum;
        n_vfill = r_vfill; n_ifill = r_ifill;
        n_vslot = r_vslot; n_islot = r_islot;
        n_vlatest = r_vlatest;
        n_vavg = r_vavg;   n_iavg = r_iavg;
        n_dac = r_dac;     n_gain = r_gain;
        n_adj = r_adj;     n_vrun = r_vrun;
        n_uptime = r_uptime;
        n_short_until = r_short_until;
        n_disc_until  = r_disc_until;
        n_holdoff = r_holdoff;
        n_alarm   = r_alarm;
        n_written = r_written;
        alarm_w = r_alarm;
        off   = 1'b0;
        vcap  = 1'b0;
        dac_w = dac0;
        now_t = r_uptime + 1'b1;
        dd = r_disc_until - now_t;
        sd = r_short_until - now_t;
        h_w = '0;

        if (i_cmd.capture) n_written = 1'b0;

        if (i_cmd.update && !r_err && r_code == CMD_VOLT) begin
            n_vlatest = r_val;
            if (r_vfill >= FILL_W'(AVG_DEPTH)) n_vsum = r_vsum - SUM_W'(r_vring[r_vslot]) + SUM_W'(r_val);
            else begin
                n_vsum  = r_vsum + SUM_W'(r_val);
                n_vfill = r_vfill + 1'b1;
            end
            n_vslot = (r_vslot == AVG_IDX_W'(AVG_DEPTH - 1)) ? '0 : r_vslot + 1'b1;
        end

        if (i_cmd.update && !r_err && r_code == CMD_CURR) begin
            if (r_ifill >= FILL_W'(AVG_DEPTH)) n_isum = r_isum - SUM_W'(r_iring[r_islot]) + SUM_W'(r_val);
            else begin
                n_isum  = r_isum + SUM_W'(r_val);
                n_ifill = r_ifill + 1'b1;
            end
            n_islot = (r_islot == AVG_IDX_W'(AVG_DEPTH - 1)) ? '0 : r_islot + 1'b1;
            if (r_raw < RAW_GAIN_UP) begin
                if (r_gain < GAIN_STEP_HI) n_gain = r_gain + 1'b1;
            end else if (r_raw > RAW_GAIN_DN) begin
                if (r_gain > GAIN_STEP_LO) n_gain = r_gain - 1'b1;
            end
        end

        // one-second tick: advance uptime, rebuild the holdoff count
        if (i_cmd.update && r_code == CMD_TICK) begin
            n_uptime = now_t;
            h_w = (r_holdoff != '0) ? r_holdoff - 1'b1 : '0;
            if (r_disc_until > now_t && dd > TIME_W'(h_w)) h_w = dd[HOLD_W-1:0];
            if (r_short_until > now_t && sd > TIME_W'(h_w)) h_w = sd[HOLD_W-1:0];
            n_holdoff = h_w;
        end

        if (i_cmd.avg_write) begin
            if (is_curr) n_iavg = $signed(q_signed[SAMPLE_W-1:0]);
            else         n_vavg = $signed(q_signed[SAMPLE_W-1:0]);
        end

        if (i_cmd.tick_end && r_period != '0 && r_phase == '0) n_alarm[AL_PERIOD] = 1'b0;

        if (i_cmd.adjust && r_enable) begin
            priority if (r_gain == GAIN_STEP_LO && r_raw > RAW_OVERLOAD) begin
                n_dac = '0; n_written = 1'b1;
                n_alarm[AL_SHORT] = 1'b1;
                n_short_until = r_uptime + TIME_W'(HOLD_SHORT);
                n_holdoff = HOLD_SHORT;
            end else if (r_set_i == '0 || r_set_v == '0) begin
                n_dac = '0; n_written = 1'b1;
            end else if (short_hit) begin
                n_dac = '0; n_written = 1'b1;
                n_alarm[AL_SHORT] = 1'b1;
                n_short_until = r_uptime + TIME_W'(HOLD_SHORT);
                n_holdoff = HOLD_SHORT;
            end else begin
                if (r_short_until < r_uptime) alarm_w[AL_SHORT] = 1'b0;
                if (r_vlatest > V_OPEN_MIN && dv_cur < TRIP_VCUR && r_dac == DAC_FLOOR_U) begin
                    // open electrode: drop the drive and hold off
                    alarm_w[AL_DISC] = 1'b1;
                    n_dac = '0;
                    n_disc_until = r_uptime + TIME_W'(HOLD_DISC);
                    n_holdoff = HOLD_DISC;
                end else begin
                    if (r_disc_until < r_uptime) alarm_w[AL_DISC] = 1'b0;
                    if (r_period != '0 && !alarm_w[AL_DISC] && !alarm_w[AL_SHORT] && !r_calib
                        && r_phase != '0) begin
                        if (($signed({2'b00, lim10}) <= 22'(r_vavg) && r_phase >= r_duty)
                            || alarm_w[AL_PERIOD]) begin
                            off = 1'b1;
                            alarm_w[AL_PERIOD] = 1'b1;
                        end
                    end
                    if (alarm_w != '0 || r_holdoff != '0) off = 1'b1;
                    if (!off) begin
                        vcap = (r_adj == ADJ_VDEC) && (r_vrun < VDEC_LIMIT);
                        priority if (dv_cur < TRIP_VCUR) begin
                            dac_w = dac0 >>> 1; n_adj = ADJ_VDEC;
                        end else if (dv_avg < TRIP_VAVG) begin
                            dac_w = dac0 - 16'sd20; n_adj = ADJ_VDEC;
                        end else if (di_cur < TRIP_ICUR) begin
                            dac_w = (dac0 * 16'sd3) >>> 2; n_adj = ADJ_IDEC;
                        end else if (dv_avg < 0) begin
                            dac_w = dac0 - 16'sd1; n_adj = ADJ_VDEC;
                        end else if (di_avg < TRIP_IAVG) begin
                            dac_w = dac0 - 16'sd10; n_adj = ADJ_IDEC;
                        end else if (di_avg < 0) begin
                            dac_w = dac0 - 16'sd1; n_adj = ADJ_IDEC;
                        end else if (di_avg > RISE_BIG) begin
                            dac_w = dac0 + ((r_adj == ADJ_VDEC) ? 16'sd1 : 16'sd25);
                            n_adj = vcap ? ADJ_VDEC : ADJ_IINC;
                        end else if (di_avg > RISE_SMALL) begin
                            dac_w = dac0 + ((r_adj == ADJ_VDEC) ? 16'sd1 : 16'sd10);
                            n_adj = vcap ? ADJ_VDEC : ADJ_IINC;
                        end else if (di_avg > 0) begin
                            dac_w = dac0 + 16'sd1; n_adj = ADJ_IINC;
                        end else begin
                            dac_w = dac0;
                        end
                        if (n_adj == ADJ_VDEC) begin
                            if (r_vrun < VDEC_LIMIT) n_vrun = r_vrun + 1'b1;
                        end else begin
                            n_vrun = '0;
                        end
                        if (dac_w < DAC_FLOOR_S) dac_w = DAC_FLOOR_S;
                        if (dac_w > DAC_CEIL_S)  dac_w = DAC_CEIL_S;
                        n_dac = dac_w[DAC_W-1:0];
                    end else begin
                        n_dac = '0;
                    end
                end
                n_alarm = alarm_w;
                n_written = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1; r_calib <= 1'b0;
            r_set_v <= '0; r_set_i <= '0; r_short_lvl <= '0;
            r_period <= '0; r_duty <= '0; r_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ENABLE:     r_enable    <= i_cfg_data[0];
                REG_CALIB:      r_calib     <= i_cfg_data[0];
                REG_SET_V:      r_set_v     <= i_cfg_data[MV_W-1:0];
                REG_SET_I:      r_set_i     <= i_cfg_data[MV_W-1:0];
                REG_SHORT_LVL:  r_short_lvl <= i_cfg_data[LVL_W-1:0];
                REG_CYC_PERIOD: r_period    <= i_cfg_data[SEC_W-1:0];
                REG_CYC_DUTY:   r_duty      <= i_cfg_data[SEC_W-1:0];
                REG_CYC_LIMIT:  r_limit     <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsum <= '0; r_isum <= '0; r_vfill <= '0; r_ifill <= '0;
            r_vslot <= '0; r_islot <= '0; r_vlatest <= '0;
            r_vavg <= '0; r_iavg <= '0;
            r_dac <= '0; r_gain <= GAIN_STEP_LO; r_adj <= ADJ_NONE; r_vrun <= '0;
            r_uptime <= '0; r_short_until <= '0; r_disc_until <= '0;
            r_holdoff <= '0; r_alarm <= '0; r_written <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_vsum <= n_vsum; r_isum <= n_isum; r_vfill <= n_vfill; r_ifill <= n_ifill;
            r_vslot <= n_vslot; r_islot <= n_islot; r_vlatest <= n_vlatest;
            r_vavg <= n_vavg; r_iavg <= n_iavg;
            r_dac <= n_dac; r_gain <= n_gain; r_adj <= n_adj; r_vrun <= n_vrun;
            r_uptime <= n_uptime; r_short_until <= n_short_until;
            r_disc_until <= n_disc_until; r_holdoff <= n_holdoff;
            r_alarm <= n_alarm; r_written <= n_written;
            if (i_cmd.load_out)  r_o_valid <= 1'b1;
            else if (i_out_ready) r_o_valid <= 1'b0;
        end
    end

    // payload: request capture, ring entries, divider results, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= t_cmd_code'(i_command);
            r_err  <= i_sample_error;
            r_raw  <= i_raw_code;
            r_val  <= i_sample_value;
        end
        if (i_cmd.update && !r_err && r_code == CMD_VOLT) r_vring[r_vslot] <= r_val;
        if (i_cmd.update && !r_err && r_code == CMD_CURR) r_iring[r_islot] <= r_val;
        if (i_cmd.div_start && !i_cmd.div_mod) r_neg <= (sum_sel < 0);
        if (i_cmd.mod_write) r_phase <= div_rem;
        if (i_cmd.load_out) begin
            o_dac_value       <= r_dac;
            o_dac_written     <= r_written;
            o_adc_gain        <= r_gain;
            o_flag_disconnect <= r_alarm[AL_DISC];
            o_flag_short      <= r_alarm[AL_SHORT];
            o_flag_period_off <= r_alarm[AL_PERIOD];
            o_holdoff_seconds <= r_holdoff;
            o_last_adjust     <= r_adj;
            o_voltage_average <= r_vavg;
            o_current_average <= r_iavg;
        end
    end

    assign o_out_valid = r_o_valid;

    a_dac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dac == '0) || (r_dac >= DAC_FLOOR_U))
        else $error("DAC level left the regulated range");
    a_vrun_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vrun <= VDEC_LIMIT)
        else $error("voltage-decrease run count past its limit");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vfill <= FILL_W'(AVG_DEPTH)) && (r_ifill <= FILL_W'(AVG_DEPTH)))
        else $error("averaging fill count past the ring depth");
endmodule

### src/cc_cv_dac_regulator.sv
// Top level of the CC/CV DAC regulator: joins the sequencer and datapath
// to the three handshake channels. Depends on ccdr_pkg, ccdr_ifs, ccdr_ctrl, ccdr_dp.

// Constant-current / constant-voltage regulator driving a 12-bit DAC. Each
// request on the input channel is a voltage sample, a current sample or a
// one-second tick, and yields exactly one result showing the DAC level,
// gain step, alarm flags, holdoff and both moving averages. One request is
// in flight at a time. Valid voltage and current samples and ticks pass
// through the shared one-bit-per-cycle divider that forms the averages
// and the cycle phase (uptime modulo period); anything else skips it.
// Current samples make two passes: average, then phase. Results wait in
// an output register, so a slow sink stalls only the last step. Register
// writes are always accepted and must happen while no request is in flight.
module cc_cv_dac_regulator import ccdr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccdr_in_if.sink    i_in,
    ccdr_out_if.source o_out,
    ccdr_cfg_if.sink   i_cfg
);
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic [1:0] w_adj;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.last_adjust = w_adj;

    // sequencer: hold each request until its result is loaded into the output register
    ccdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    ccdr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_in_valid        (i_in.valid),
        .i_command         (i_in.command),
        .i_sample_error    (i_in.sample_error),
        .i_raw_code        (i_in.raw_code),
        .i_sample_value    (i_in.sample_value),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_dac_value       (o_out.dac_value),
        .o_dac_written     (o_out.dac_written),
        .o_adc_gain        (o_out.adc_gain),
        .o_flag_disconnect (o_out.flag_disconnect),
        .o_flag_short      (o_out.flag_short),
        .o_flag_period_off (o_out.flag_period_off),
        .o_holdoff_seconds (o_out.holdoff_seconds),
        .o_last_adjust     (w_adj),
        .o_voltage_average (o_out.voltage_average),
        .o_current_average (o_out.current_average)
    );
endmodule
